FILE: rtl/core/mcopa_pkg.sv
// shared types and constants of the option payoff averager
// no dependencies

package mcopa_pkg;

  typedef enum logic [2:0] {
    REG_SPOT   = 3'd0,
    REG_STRIKE = 3'd1,
    REG_DRIFT  = 3'd2,
    REG_VOL    = 3'd3,
    REG_DISC   = 3'd4,
    REG_SPB    = 3'd5
  } cfg_reg_e;

  localparam logic [31:0]        SpotReset   = 32'd6553600;
  localparam logic [31:0]        StrikeReset = 32'd6553600;
  localparam logic signed [31:0] DriftReset  = 32'sd23488102;
  localparam logic [30:0]        VolReset    = 31'd67108864;
  localparam logic [31:0]        DiscReset   = 32'd3886247592;
  localparam logic [20:0]        SpbReset    = 21'd5000;

  localparam int XW = 35;
  localparam int CNT_W = 21;
  localparam int ACC_W = 53;

  localparam logic [30:0]          Log2eQ30  = 31'd1549082005;
  localparam logic [29:0]          Ln2Q30    = 30'd744261118;
  localparam logic signed [36:0]   ExpClamp  = 37'sh0_2_0000_0000;
  localparam logic signed [35:0]   TOffset   = 36'sh4_0000_0000;
  localparam logic [3:0]           SeriesTerms = 4'd12;
  localparam logic [31:0]          Unit30    = 32'h4000_0000;
  localparam logic [31:0]          PriceMax  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0]        spot;
    logic [31:0]        strike;
    logic signed [31:0] drift;
    logic [30:0]        vol;
    logic [31:0]        disc;
    logic [20:0]        spb;
  } cfg_t;

endpackage

FILE: rtl/core/mcopa_if.sv
// handshake channels of the option payoff averager
// no dependencies

interface mcopa_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gauss_sample;
  modport source (output valid, gauss_sample, input ready);
  modport sink (input valid, gauss_sample, output ready);
endinterface

interface mcopa_result_if #(parameter int BLOCK_INDEX_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic [BLOCK_INDEX_WIDTH-1:0] block_number;
  logic [31:0]                  call_block_mean;
  logic [31:0]                  put_block_mean;
  logic [31:0]                  call_running_mean;
  logic [31:0]                  put_running_mean;
  modport source (output valid, block_number, call_block_mean, put_block_mean,
                  call_running_mean, put_running_mean, input ready);
  modport sink (input valid, block_number, call_block_mean, put_block_mean,
                call_running_mean, put_running_mean, output ready);
endinterface

interface mcopa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [31:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/core/mcopa_fifo.sv
// small queue between the exponent front end and the pricing back end
// no dependencies

module mcopa_fifo #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]      cnt_q, cnt_d;

  assign full_o     = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/mcopa_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies

module mcopa_div #(
  parameter int DIVIDEND_W = 53,
  parameter int DIVISOR_W  = 21
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DIVIDEND_W-1:0]        dividend_i,
  input  logic [DIVISOR_W-1:0]         divisor_i,
  input  logic [$clog2(DIVIDEND_W+1)-1:0] steps_i,
  output logic                         done_o,
  output logic [DIVIDEND_W-1:0]        quotient_o
);

  localparam int SW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, done_q;
  logic [SW-1:0]         cnt_q;
  logic [DIVISOR_W-1:0]  rem_q, div_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W:0]    trial, diff;
  logic                  qbit;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign qbit  = (trial >= {1'b0, div_q});
  assign diff  = qbit ? trial - {1'b0, div_q} : trial;

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= diff[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], qbit};
    end
  end

endmodule

FILE: rtl/core/mcopa_front.sv
// front end: takes samples, forms the clamped exponent and queues it
// depends on mcopa_pkg, mcopa_if

module mcopa_front import mcopa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  mcopa_sample_if.sink      sample_if,
  output logic              push_o,
  output logic [XW-1:0]     push_x_o,
  input  logic              full_i
);

  logic                  s1_v_q;
  logic                  neg_q;
  logic [62:0]           prod_q;
  logic                  fire;
  logic [31:0]           mag;
  logic signed [36:0]    drift_ext, pe, x_raw;

  assign push_o          = s1_v_q && !full_i;
  assign sample_if.ready = !s1_v_q || !full_i;
  assign fire            = sample_if.valid && sample_if.ready;

  assign mag = sample_if.gauss_sample[31] ? (~sample_if.gauss_sample + 32'd1)
                                          : sample_if.gauss_sample;

  assign drift_ext = 37'(cfg_i.drift);
  assign pe        = $signed({2'b00, prod_q[62:28]});
  assign x_raw     = neg_q ? drift_ext - pe : drift_ext + pe;

  always_comb begin
    if (x_raw > ExpClamp) begin
      push_x_o = XW'(ExpClamp);
    end else if (x_raw < -ExpClamp) begin
      push_x_o = XW'(-ExpClamp);
    end else begin
      push_x_o = x_raw[XW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (fire) begin
      s1_v_q <= 1'b1;
    end else if (push_o) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      neg_q  <= sample_if.gauss_sample[31];
      prod_q <= {32'b0, cfg_i.vol} * {31'b0, mag};
    end
  end

endmodule

FILE: rtl/core/mcopa_back.sv
// back end: exponential, payoffs, block accumulation and block means
// depends on mcopa_pkg, mcopa_if, mcopa_div

module mcopa_back import mcopa_pkg::*; #(
  parameter int BLOCK_INDEX_WIDTH = 16,
  parameter int DIV_DW = 53,
  parameter int DIV_VW = 21
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  output logic          pop_o,
  input  logic [XW-1:0] pop_x_i,
  input  logic          empty_i,
  mcopa_result_if.source result_if
);

  localparam int SUM_W = 32 + BLOCK_INDEX_WIDTH;
  localparam int SW    = $clog2(DIV_DW + 1);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'h001,
    ST_TMUL   = 12'h002,
    ST_GMUL   = 12'h004,
    ST_HMUL   = 12'h008,
    ST_HREC   = 12'h010,
    ST_PMUL   = 12'h020,
    ST_SHIFT  = 12'h040,
    ST_PAYMUL = 12'h080,
    ST_ACC    = 12'h100,
    ST_DIV_S  = 12'h200,
    ST_DIV_W  = 12'h400,
    ST_OUT    = 12'h800
  } state_e;

  state_e state_q, state_d;

  logic signed [XW-1:0]        x_q;
  logic signed [35:0]          t_q;
  logic signed [7:0]           k_q;
  logic [29:0]                 g_q;
  logic [31:0]                 r_q, hq_q;
  logic [3:0]                  n_q;
  logic [63:0]                 p_q;
  logic [31:0]                 price_q, price_d, dc_q, dp_q;
  logic [1:0]                  sel_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [ACC_W-1:0]            cacc_q, pacc_q;
  logic [BLOCK_INDEX_WIDTH-1:0] blk_q, blk_next;
  logic [SUM_W-1:0]            csum_q, psum_q;
  logic [31:0]                 cmean_q, pmean_q, crun_q, prun_q;
  logic                        out_v_q;

  logic [33:0]  xm;
  logic [64:0]  tmul;
  logic [35:0]  u;
  logic [57:0]  gmul;
  logic [61:0]  hmul;
  logic [35:0]  recip;
  logic [67:0]  rmul;
  logic [31:0]  call_pay, put_pay;
  logic [63:0]  cmul, pmul;
  logic [CNT_W-1:0] cnt_inc, limit;

  logic              div_start, div_done;
  logic [DIV_DW-1:0] div_dividend, div_quo;
  logic [DIV_VW-1:0] div_divisor;
  logic [SW-1:0]     div_steps;

  logic signed [7:0] sh;
  logic [6:0]        amt;
  logic [63:0]       shl, shr;

  // ceil(2^35 / n), exact floor division for dividends below 2^32
  function automatic logic [35:0] recip_q35(logic [3:0] n);
    logic [35:0] m;
    case (n)
      4'd2:    m = 36'd17179869184;
      4'd3:    m = 36'd11453246123;
      4'd4:    m = 36'd8589934592;
      4'd5:    m = 36'd6871947674;
      4'd6:    m = 36'd5726623062;
      4'd7:    m = 36'd4908534053;
      4'd8:    m = 36'd4294967296;
      4'd9:    m = 36'd3817748708;
      4'd10:   m = 36'd3435973837;
      4'd11:   m = 36'd3123612579;
      4'd12:   m = 36'd2863311531;
      default: m = 36'd34359738368;
    endcase
    return m;
  endfunction

  assign xm   = x_q[XW-1] ? 34'(-x_q) : 34'(x_q);
  assign tmul = {31'b0, xm} * {34'b0, Log2eQ30};
  assign u    = 36'(t_q + TOffset);
  assign gmul = {30'b0, u[27:0]} * {28'b0, Ln2Q30};
  assign hmul = {30'b0, g_q} * {30'b0, r_q};
  assign recip = recip_q35(n_q);
  assign rmul  = {36'b0, hq_q} * {32'b0, recip};

  assign call_pay = (price_q > cfg_i.strike) ? price_q - cfg_i.strike : 32'd0;
  assign put_pay  = (cfg_i.strike > price_q) ? cfg_i.strike - price_q : 32'd0;
  assign cmul     = {32'b0, call_pay} * {32'b0, cfg_i.disc};
  assign pmul     = {32'b0, put_pay} * {32'b0, cfg_i.disc};

  assign cnt_inc  = cnt_q + 1'b1;
  assign limit    = (cfg_i.spb == '0) ? CNT_W'(1) : cfg_i.spb;
  assign blk_next = blk_q + 1'b1;

  // price = p * 2^(k-30), saturated
  assign sh  = k_q - 8'sd30;
  assign shl = p_q << amt;
  assign shr = p_q >> amt;
  always_comb begin
    amt = sh[7] ? 7'(-sh) : sh[6:0];
    if (!sh[7]) begin
      if (amt >= 7'd32) begin
        price_d = (p_q != '0) ? PriceMax : 32'd0;
      end else if ((p_q >> (7'd32 - amt)) != '0) begin
        price_d = PriceMax;
      end else begin
        price_d = shl[31:0];
      end
    end else if (amt >= 7'd64) begin
      price_d = 32'd0;
    end else if (shr[63:32] != '0) begin
      price_d = PriceMax;
    end else begin
      price_d = shr[31:0];
    end
  end

  assign div_start = (state_q == ST_DIV_S);
  assign div_steps = SW'(DIV_DW);

  always_comb begin
    div_divisor = DIV_VW'(cnt_q);
    case (sel_q)
      2'd0: div_dividend = DIV_DW'(cacc_q);
      2'd1: div_dividend = DIV_DW'(pacc_q);
      2'd2: div_dividend = DIV_DW'(csum_q);
      default: div_dividend = DIV_DW'(psum_q);
    endcase
    if (sel_q[1]) begin
      div_divisor = DIV_VW'(blk_q);
    end
  end

  mcopa_div #(
    .DIVIDEND_W (DIV_DW),
    .DIVISOR_W  (DIV_VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (!empty_i) state_d = ST_TMUL;
      ST_TMUL:   state_d = ST_GMUL;
      ST_GMUL:   state_d = ST_HMUL;
      ST_HMUL:   state_d = ST_HREC;
      ST_HREC:   state_d = (n_q == 4'd1) ? ST_PMUL : ST_HMUL;
      ST_PMUL:   state_d = ST_SHIFT;
      ST_SHIFT:  state_d = ST_PAYMUL;
      ST_PAYMUL: state_d = ST_ACC;
      ST_ACC:    state_d = (cnt_inc >= limit) ? ST_DIV_S : ST_IDLE;
      ST_DIV_S:  state_d = ST_DIV_W;
      ST_DIV_W: begin
        if (div_done) begin
          if ((sel_q == 2'd3) || ((sel_q == 2'd1) && (blk_q == '0))) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_DIV_S;
          end
        end
      end
      ST_OUT:    if (!out_v_q || result_if.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= '0;
      cnt_q   <= '0;
      cacc_q  <= '0;
      pacc_q  <= '0;
      blk_q   <= '0;
      csum_q  <= '0;
      psum_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC) begin
        cnt_q  <= cnt_inc;
        cacc_q <= cacc_q + ACC_W'(dc_q);
        pacc_q <= pacc_q + ACC_W'(dp_q);
        sel_q  <= '0;
      end
      if ((state_q == ST_DIV_W) && div_done) begin
        sel_q <= sel_q + 1'b1;
      end
      if ((state_q == ST_OUT) && (!out_v_q || result_if.ready)) begin
        out_v_q <= 1'b1;
        cnt_q   <= '0;
        cacc_q  <= '0;
        pacc_q  <= '0;
        blk_q   <= blk_next;
        if (blk_next == '0) begin
          csum_q <= '0;
          psum_q <= '0;
        end else begin
          csum_q <= csum_q + SUM_W'(cmean_q);
          psum_q <= psum_q + SUM_W'(pmean_q);
        end
      end else if (out_v_q && result_if.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_q <= pop_x_i;
    end
    if (state_q == ST_TMUL) begin
      t_q <= x_q[XW-1] ? -$signed({2'b00, tmul[63:30]}) : $signed({2'b00, tmul[63:30]});
    end
    if (state_q == ST_GMUL) begin
      k_q <= $signed(u[35:28]) - 8'sd64;
      g_q <= gmul[57:28];
      r_q <= Unit30;
      n_q <= SeriesTerms;
    end
    if (state_q == ST_HMUL) begin
      hq_q <= hmul[61:30];
    end
    if (state_q == ST_HREC) begin
      r_q <= Unit30 + rmul[66:35];
      n_q <= n_q - 1'b1;
    end
    if (state_q == ST_PMUL) begin
      p_q <= {32'b0, cfg_i.spot} * {32'b0, r_q};
    end
    if (state_q == ST_SHIFT) begin
      price_q <= price_d;
    end
    if (state_q == ST_PAYMUL) begin
      dc_q <= cmul[63:32];
      dp_q <= pmul[63:32];
    end
    if ((state_q == ST_DIV_W) && div_done) begin
      case (sel_q)
        2'd0: cmean_q <= div_quo[31:0];
        2'd1: begin
          pmean_q <= div_quo[31:0];
          crun_q  <= '0;
          prun_q  <= '0;
        end
        2'd2: crun_q <= div_quo[31:0];
        default: prun_q <= div_quo[31:0];
      endcase
    end
    if ((state_q == ST_OUT) && (!out_v_q || result_if.ready)) begin
      result_if.block_number      <= blk_q;
      result_if.call_block_mean   <= cmean_q;
      result_if.put_block_mean    <= pmean_q;
      result_if.call_running_mean <= crun_q;
      result_if.put_running_mean  <= prun_q;
    end
  end

  assign result_if.valid = out_v_q;

endmodule

FILE: rtl/core/monte_carlo_option_payoff_averager_core.sv
// top level: config registers, exponent front end, queue, pricing back end
// depends on mcopa_pkg, mcopa_if, mcopa_fifo, mcopa_front, mcopa_back
// the front end and queue can accept new samples while the back end still prices
// earlier ones; the back end prices one sample at a time, its pace set by the
// twelve-term exponential series; block end adds four divisions, two for the
// first block
// reset: registers to defaults, counters and sums cleared, no clearing pass

module monte_carlo_option_payoff_averager_core import mcopa_pkg::*; #(
  parameter int BLOCK_INDEX_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mcopa_sample_if.sink   sample_if,
  mcopa_result_if.source result_if,
  mcopa_cfg_if.sink      cfg_if
);

  localparam int SUM_W  = 32 + BLOCK_INDEX_WIDTH;
  localparam int DIV_DW = (SUM_W > ACC_W) ? SUM_W : ACC_W;
  localparam int DIV_VW = (BLOCK_INDEX_WIDTH > CNT_W) ? BLOCK_INDEX_WIDTH : CNT_W;

  cfg_t          cfg_q;
  logic          push, full, pop, empty;
  logic [XW-1:0] push_x, pop_x;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spot   <= SpotReset;
      cfg_q.strike <= StrikeReset;
      cfg_q.drift  <= DriftReset;
      cfg_q.vol    <= VolReset;
      cfg_q.disc   <= DiscReset;
      cfg_q.spb    <= SpbReset;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_e'(cfg_if.reg_index))
        REG_SPOT:   cfg_q.spot   <= cfg_if.wdata;
        REG_STRIKE: cfg_q.strike <= cfg_if.wdata;
        REG_DRIFT:  cfg_q.drift  <= $signed(cfg_if.wdata);
        REG_VOL:    cfg_q.vol    <= cfg_if.wdata[30:0];
        REG_DISC:   cfg_q.disc   <= cfg_if.wdata;
        REG_SPB:    cfg_q.spb    <= cfg_if.wdata[20:0];
        default: ;
      endcase
    end
  end

  mcopa_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .sample_if (sample_if),
    .push_o    (push),
    .push_x_o  (push_x),
    .full_i    (full)
  );

  mcopa_fifo #(
    .WIDTH (XW),
    .DEPTH (4)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_x),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_x),
    .empty_o     (empty)
  );

  mcopa_back #(
    .BLOCK_INDEX_WIDTH (BLOCK_INDEX_WIDTH),
    .DIV_DW            (DIV_DW),
    .DIV_VW            (DIV_VW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .pop_o     (pop),
    .pop_x_i   (pop_x),
    .empty_i   (empty),
    .result_if (result_if)
  );

endmodule

FILE: bench/tb_monte_carlo_option_payoff_averager_core.sv
// testbench of the option payoff averager: directed table, then random samples
// checked against a payoff predictor at the block's fixed-point widths
// depends on mcopa_pkg, mcopa_if and monte_carlo_option_payoff_averager_core

module tb_monte_carlo_option_payoff_averager_core;
  import mcopa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegUnused = 3'd6;
  localparam int SettleCycles = 1200;

  typedef struct {
    logic [15:0] block_number;
    logic [31:0] call_block_mean;
    logic [31:0] put_block_mean;
    logic [31:0] call_running_mean;
    logic [31:0] put_running_mean;
  } block_means_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    logic [2:0]   reg_index;
    logic [31:0]  wdata;
    logic         typed;
    block_means_t means;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  bit   quiet;

  mcopa_sample_if smp ();
  mcopa_result_if #(.BLOCK_INDEX_WIDTH(16)) res ();
  mcopa_cfg_if    cfg ();

  monte_carlo_option_payoff_averager_core #(.BLOCK_INDEX_WIDTH(16)) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_if(smp),
    .result_if(res),
    .cfg_if   (cfg)
  );

  // predictor copy of registers and state
  logic [31:0] spot_q, strike_q, disc_q;
  logic signed [31:0] drift_q;
  logic [30:0] vol_q;
  logic [20:0] spb_q;
  logic [20:0] n_samples;
  longint unsigned call_acc, put_acc, call_sum, put_sum;
  logic [15:0] blk_cnt;

  block_means_t means_q[$];
  stim_row_t    rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [31:0] terminal_price(logic signed [31:0] z);
    longint zz, prod, x, t;
    longint unsigned mag, xm, tm, u, g, r, p;
    int k, sh;
    zz = z;
    mag = (zz < 0) ? -zz : zz;
    prod = (longint'(vol_q) * mag) >> 28;
    x = (zz < 0) ? longint'(drift_q) - prod : longint'(drift_q) + prod;
    if (x > (64'sd32 <<< 28)) x = 64'sd32 <<< 28;
    if (x < -(64'sd32 <<< 28)) x = -(64'sd32 <<< 28);
    xm = (x < 0) ? -x : x;
    tm = (xm * longint'(Log2eQ30)) >> 30;
    t = (x < 0) ? -longint'(tm) : longint'(tm);
    u = t + (64'sd64 <<< 28);
    k = int'(u >> 28) - 64;
    g = ((u & 64'h0FFF_FFFF) * longint'(Ln2Q30)) >> 28;
    r = 64'd1 << 30;
    for (int n = 12; n >= 1; n--) r = (64'd1 << 30) + ((g * r) >> 30) / n;
    p = longint'(spot_q) * r;
    sh = k - 30;
    if (sh >= 0) begin
      if (p == 0) return 32'd0;
      if (sh >= 32 || p > (64'hFFFF_FFFF >> sh)) return PriceMax;
      return 32'(p << sh);
    end
    p = p >> (-sh);
    return (p > 64'hFFFF_FFFF) ? PriceMax : p[31:0];
  endfunction

  // returns 1 when the sample closes a block
  function automatic bit payoff_step(logic signed [31:0] z, output block_means_t m);
    logic [31:0] price;
    longint unsigned call_p, put_p, call_m, put_m;
    logic [20:0] lim;
    price = terminal_price(z);
    call_p = (price > strike_q) ? price - strike_q : 0;
    put_p = (strike_q > price) ? strike_q - price : 0;
    lim = (spb_q == 0) ? 21'd1 : spb_q;
    call_acc += (call_p * disc_q) >> 32;
    put_acc += (put_p * disc_q) >> 32;
    n_samples = n_samples + 21'd1;
    if (n_samples < lim) return 1'b0;
    call_m = call_acc / n_samples;
    put_m = put_acc / n_samples;
    m.block_number = blk_cnt;
    m.call_block_mean = call_m[31:0];
    m.put_block_mean = put_m[31:0];
    m.call_running_mean = (blk_cnt != 0) ? 32'(call_sum / blk_cnt) : 32'd0;
    m.put_running_mean = (blk_cnt != 0) ? 32'(put_sum / blk_cnt) : 32'd0;
    if (blk_cnt + 16'd1 == 16'd0) begin
      call_sum = 0;
      put_sum = 0;
    end else begin
      call_sum += call_m;
      put_sum += put_m;
    end
    blk_cnt = blk_cnt + 16'd1;
    n_samples = '0;
    call_acc = 0;
    put_acc = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t block %s: got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (means_q.size() == 0) begin
        report_mismatch("unexpected", 32'(res.block_number), 32'd0);
      end else begin
        block_means_t w;
        w = means_q.pop_front();
        if (res.block_number !== w.block_number)
          report_mismatch("number", 32'(res.block_number), 32'(w.block_number));
        if (res.call_block_mean !== w.call_block_mean)
          report_mismatch("call mean", res.call_block_mean, w.call_block_mean);
        if (res.put_block_mean !== w.put_block_mean)
          report_mismatch("put mean", res.put_block_mean, w.put_block_mean);
        if (res.call_running_mean !== w.call_running_mean)
          report_mismatch("call running", res.call_running_mean, w.call_running_mean);
        if (res.put_running_mean !== w.put_running_mean)
          report_mismatch("put running", res.put_running_mean, w.put_running_mean);
      end
    end
    res.ready <= rst_ni && (quiet || $urandom_range(99) >= 36);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata <= data;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    case (idx)
      REG_SPOT:   spot_q = data;
      REG_STRIKE: strike_q = data;
      REG_DRIFT:  drift_q = data;
      REG_VOL:    vol_q = data[30:0];
      REG_DISC:   disc_q = data;
      REG_SPB:    spb_q = data[20:0];
      default: ;
    endcase
    cfg.valid <= 1'b0;
  endtask

  task automatic send_sample(logic signed [31:0] z, bit typed, block_means_t tm);
    block_means_t m;
    while (!quiet && $urandom_range(99) < 36) begin
      smp.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp.valid <= 1'b1;
    smp.gauss_sample <= z;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
    if (payoff_step(z, m)) means_q.push_back(typed ? tm : m);
  endtask

  task automatic settle();
    smp.valid <= 1'b0;
    while (means_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void add_cfg(logic [2:0] idx, logic [31:0] data);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.reg_index = idx;
    r.wdata = data;
    r.typed = 1'b0;
    rows.push_back(r);
  endfunction

  function automatic void add_smp(logic [31:0] z, logic typed = 1'b0,
                                  logic [31:0] put_m = 0, logic [31:0] put_run = 0,
                                  logic [15:0] blk = 0);
    stim_row_t r;
    r.kind = ROW_SAMPLE;
    r.wdata = z;
    r.typed = typed;
    r.means = '{blk, 32'd0, put_m, 32'd0, put_run};
    rows.push_back(r);
  endfunction

  initial begin
    block_means_t none;
    bit last_cfg;
    rst_ni = 1'b0;
    quiet = 1'b0;
    mismatches = 0;
    smp.valid = 1'b0;
    smp.gauss_sample = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.reg_index = REG_SPOT;
    cfg.wdata = '0;
    spot_q = SpotReset; strike_q = StrikeReset; drift_q = DriftReset;
    vol_q = VolReset; disc_q = DiscReset; spb_q = SpbReset;
    n_samples = '0; call_acc = 0; put_acc = 0; call_sum = 0; put_sum = 0;
    blk_cnt = '0;
    none = '{default: '0};

    // zero spot: price is zero, put pays the whole discounted strike
    add_cfg(REG_SPB, 32'd1);
    add_cfg(REG_SPOT, 32'd0);
    add_cfg(REG_DISC, 32'hFFFF_FFFF);
    add_smp(32'h8000_0000, 1'b1, 32'd6553599, 32'd0, 16'd0);
    add_smp(32'h7FFF_FFFF, 1'b1, 32'd6553599, 32'd6553599, 16'd1);
    add_cfg(RegUnused, 32'hFFFF_FFFF);
    add_smp(32'd0, 1'b1, 32'd6553599, 32'd6553599, 16'd2);
    // extremes of spot, drift, volatility and strike
    add_cfg(REG_SPOT, 32'hFFFF_FFFF);
    add_cfg(REG_VOL, 32'hFFFF_FFFF);
    add_cfg(REG_DRIFT, 32'h7FFF_FFFF);
    add_smp(32'h7FFF_FFFF);
    add_smp(32'h8000_0000);
    add_cfg(REG_DRIFT, 32'h8000_0000);
    add_cfg(REG_STRIKE, 32'hFFFF_FFFF);
    add_smp(32'h7FFF_FFFF);
    add_smp(32'h8000_0000);
    add_smp(32'd0);
    // zero block size, then block size lowered mid-block
    add_cfg(REG_SPB, 32'h0020_0000);
    add_cfg(REG_STRIKE, 32'd0);
    add_smp(32'h1000_0000);
    add_cfg(REG_SPB, 32'd4);
    add_cfg(REG_DRIFT, 32'd0);
    add_cfg(REG_VOL, 32'd67108864);
    add_cfg(REG_SPOT, 32'd6553600);
    add_cfg(REG_STRIKE, 32'd6553600);
    add_smp(32'h1000_0000);
    add_smp(32'hF000_0000);
    add_cfg(REG_SPB, 32'd1);
    add_smp(32'h0800_0000);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    last_cfg = 1'b1;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (!last_cfg) settle();
        write_reg(rows[i].reg_index, rows[i].wdata);
        last_cfg = 1'b1;
      end else begin
        send_sample(rows[i].wdata, rows[i].typed, rows[i].means);
        last_cfg = 1'b0;
      end
    end

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      write_reg(REG_SPOT, (ph == 6) ? 32'hFFFF_FFFF :
                $urandom_range(1) ? $urandom : $urandom_range(32'h00C8_0000, 32'h0032_0000));
      write_reg(REG_STRIKE, (ph == 6) ? 32'd0 :
                $urandom_range(1) ? $urandom : $urandom_range(32'h00C8_0000, 32'h0032_0000));
      write_reg(REG_DRIFT, (ph == 5) ? 32'h8000_0000 :
                $urandom_range(1) ? $urandom : $urandom_range(32'h0400_0000) - 32'h0200_0000);
      write_reg(REG_VOL, (ph == 5) ? 32'h7FFF_FFFF :
                $urandom_range(1) ? $urandom : $urandom_range(32'h1000_0000));
      write_reg(REG_DISC, (ph == 4) ? 32'd0 : $urandom);
      write_reg(REG_SPB, (ph == 3) ? 32'd0 : $urandom_range(6, 1));
      for (int i = 0; i < 200; i++) begin
        quiet = (ph == 2 && i >= 40 && i < 160);
        send_sample($urandom_range(3) == 0 ? $urandom :
                    $urandom_range(32'h3000_0000) - 32'h1800_0000, 1'b0, none);
      end
      quiet = 1'b0;
    end

    smp.valid <= 1'b0;
    while (means_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
